// File: src/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg: shared types and constants for the all-pairs shortest path unit
// Word formats, command codes, distance store entry and sequencer states.
// ----------------------------------------------------------------------------
package apsp_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int NODE_W        = 7;
	localparam int DIST_W        = 6;
	localparam int HOP_W         = 16;

	localparam logic [DIST_W-1:0] DIST_SAT = 6'd63;

	localparam logic STAT_OK        = 1'b0;
	localparam logic STAT_BAD_INDEX = 1'b1;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_EDGE  = 2'd1,
		FUNC_RELAX = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef struct packed {
		func_t             func;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} in_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              reachable;
		logic              status;
		logic [NODE_W-1:0] node_count;
	} out_word_t;

	typedef struct packed {
		logic             reach;
		logic [HOP_W-1:0] hop;
	} entry_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EDGE_AB,
		ST_EDGE_BA,
		ST_READ,
		ST_READ_CHK,
		ST_ROW_RD,
		ST_ROW_CHK,
		ST_COL_RD,
		ST_COL_WR,
		ST_DONE
	} state_t;

endpackage

// File: src/apsp_mem.sv
// ----------------------------------------------------------------------------
// apsp_mem: distance store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module apsp_mem #(
	parameter int ADDR_W = 12
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  apsp_pkg::entry_t     wdata,
	input  logic [ADDR_W-1:0]    raddr0,
	input  logic [ADDR_W-1:0]    raddr1,
	output apsp_pkg::entry_t     rdata0,
	output apsp_pkg::entry_t     rdata1
);

	localparam int DEPTH = 1 << ADDR_W;

	apsp_pkg::entry_t store_q [DEPTH];
	apsp_pkg::entry_t rd0_q;
	apsp_pkg::entry_t rd1_q;

	// write one entry, read two
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rd0_q <= store_q[raddr0];
		rd1_q <= store_q[raddr1];
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

// File: src/apsp_ctrl.sv
// ----------------------------------------------------------------------------
// apsp_ctrl: command sequencer
// Decodes commands, sweeps the store on clear, and runs the relaxation loops
// as read, compare and write-back steps against the distance store.
// ----------------------------------------------------------------------------
module apsp_ctrl #(
	parameter int MAX_NODES = apsp_pkg::MAX_NODES_DEF,
	parameter int IDX_W     = $clog2(MAX_NODES),
	parameter int ADDR_W    = 2 * IDX_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  apsp_pkg::in_word_t   in_data,
	output logic                 res_valid,
	input  logic                 res_free,
	output apsp_pkg::out_word_t  res_data,
	output logic                 mem_we,
	output logic [ADDR_W-1:0]    mem_waddr,
	output apsp_pkg::entry_t     mem_wdata,
	output logic [ADDR_W-1:0]    mem_raddr0,
	output logic [ADDR_W-1:0]    mem_raddr1,
	input  apsp_pkg::entry_t     mem_rdata0,
	input  apsp_pkg::entry_t     mem_rdata1
);

	localparam int NW = apsp_pkg::NODE_W;
	localparam int HW = apsp_pkg::HOP_W;
	localparam int DW = apsp_pkg::DIST_W;
	localparam logic [IDX_W-1:0] MAX_LAST = IDX_W'(MAX_NODES - 1);

	apsp_pkg::state_t state_q, state_d;
	logic [NW-1:0]    vc_q, vc_d;
	logic [IDX_W-1:0] m_q, m_d, r_q, r_d, c_q, c_d, last_q, last_d;
	logic             clr_resp_q, clr_resp_d;
	logic [IDX_W-1:0] ia_q, ia_d, ib_q, ib_d;
	logic [HW-1:0]    drm_q, drm_d;
	logic [DW-1:0]    res_dist_q, res_dist_d;
	logic             res_reach_q, res_reach_d;
	logic             res_stat_q, res_stat_d;

	logic             a_ok, b_ok;
	logic [IDX_W-1:0] ia_in, ib_in;
	logic [NW-1:0]    vc_a;
	logic [HW:0]      via;
	apsp_pkg::state_t adv_state;
	logic [IDX_W-1:0] adv_m, adv_r;

	// check and convert the vertex indices
	assign a_ok  = (in_data.node_a != '0) && (32'(in_data.node_a) <= MAX_NODES);
	assign b_ok  = (in_data.node_b != '0) && (32'(in_data.node_b) <= MAX_NODES);
	assign ia_in = IDX_W'(in_data.node_a - NW'(1));
	assign ib_in = IDX_W'(in_data.node_b - NW'(1));
	assign vc_a  = (in_data.node_a > vc_q) ? in_data.node_a : vc_q;

	// candidate path length through the current intermediate vertex
	assign via = {1'b0, drm_q} + {1'b0, mem_rdata0.hop};

	// next row or next intermediate vertex of the relaxation
	always_comb begin
		adv_state = apsp_pkg::ST_ROW_RD;
		adv_m     = m_q;
		adv_r     = r_q + IDX_W'(1);
		if (r_q == last_q) begin
			adv_r = '0;
			adv_m = m_q + IDX_W'(1);
			if (m_q == last_q) begin
				adv_state = apsp_pkg::ST_DONE;
			end
		end
	end

	assign in_ready = (state_q == apsp_pkg::ST_IDLE);
	assign res_valid = (state_q == apsp_pkg::ST_DONE);

	always_comb begin
		res_data.distance   = res_dist_q;
		res_data.reachable  = res_reach_q;
		res_data.status     = res_stat_q;
		res_data.node_count = vc_q;
	end

	// next state, register updates and store accesses
	always_comb begin
		state_d     = state_q;
		vc_d        = vc_q;
		m_d         = m_q;
		r_d         = r_q;
		c_d         = c_q;
		last_d      = last_q;
		clr_resp_d  = clr_resp_q;
		ia_d        = ia_q;
		ib_d        = ib_q;
		drm_d       = drm_q;
		res_dist_d  = res_dist_q;
		res_reach_d = res_reach_q;
		res_stat_d  = res_stat_q;
		mem_we      = 1'b0;
		mem_waddr   = {r_q, c_q};
		mem_wdata   = '0;
		mem_raddr0  = {r_q, m_q};
		mem_raddr1  = {r_q, c_q};

		case (state_q)
			apsp_pkg::ST_CLEAR: begin
				mem_we          = 1'b1;
				mem_waddr       = {r_q, c_q};
				mem_wdata.reach = (r_q == c_q);
				mem_wdata.hop   = '0;
				c_d = c_q + IDX_W'(1);
				if (c_q == MAX_LAST) begin
					c_d = '0;
					r_d = r_q + IDX_W'(1);
					if (r_q == MAX_LAST) begin
						state_d = clr_resp_q ? apsp_pkg::ST_DONE : apsp_pkg::ST_IDLE;
					end
				end
			end
			apsp_pkg::ST_IDLE: begin
				if (in_valid) begin
					ia_d        = ia_in;
					ib_d        = ib_in;
					res_dist_d  = '0;
					res_reach_d = 1'b0;
					res_stat_d  = apsp_pkg::STAT_OK;
					case (in_data.func)
						apsp_pkg::FUNC_CLEAR: begin
							vc_d       = '0;
							r_d        = '0;
							c_d        = '0;
							clr_resp_d = 1'b1;
							state_d    = apsp_pkg::ST_CLEAR;
						end
						apsp_pkg::FUNC_EDGE: begin
							if (!a_ok || !b_ok) begin
								res_stat_d = apsp_pkg::STAT_BAD_INDEX;
								state_d    = apsp_pkg::ST_DONE;
							end else begin
								vc_d    = (in_data.node_b > vc_a) ? in_data.node_b : vc_a;
								state_d = (ia_in != ib_in) ? apsp_pkg::ST_EDGE_AB
								                           : apsp_pkg::ST_DONE;
							end
						end
						apsp_pkg::FUNC_RELAX: begin
							if (vc_q == '0) begin
								state_d = apsp_pkg::ST_DONE;
							end else begin
								last_d  = IDX_W'(vc_q - NW'(1));
								m_d     = '0;
								r_d     = '0;
								state_d = apsp_pkg::ST_ROW_RD;
							end
						end
						apsp_pkg::FUNC_READ: begin
							if (!a_ok || !b_ok) begin
								res_stat_d = apsp_pkg::STAT_BAD_INDEX;
								state_d    = apsp_pkg::ST_DONE;
							end else begin
								state_d = apsp_pkg::ST_READ;
							end
						end
						default: begin
							state_d = apsp_pkg::ST_DONE;
						end
					endcase
				end
			end
			apsp_pkg::ST_EDGE_AB: begin
				mem_we          = 1'b1;
				mem_waddr       = {ia_q, ib_q};
				mem_wdata.reach = 1'b1;
				mem_wdata.hop   = HW'(1);
				state_d         = apsp_pkg::ST_EDGE_BA;
			end
			apsp_pkg::ST_EDGE_BA: begin
				mem_we          = 1'b1;
				mem_waddr       = {ib_q, ia_q};
				mem_wdata.reach = 1'b1;
				mem_wdata.hop   = HW'(1);
				state_d         = apsp_pkg::ST_DONE;
			end
			apsp_pkg::ST_READ: begin
				mem_raddr0 = {ia_q, ib_q};
				state_d    = apsp_pkg::ST_READ_CHK;
			end
			apsp_pkg::ST_READ_CHK: begin
				// saturate long hop counts
				if (mem_rdata0.reach) begin
					res_reach_d = 1'b1;
					res_dist_d  = (mem_rdata0.hop > HW'(apsp_pkg::DIST_SAT))
					              ? apsp_pkg::DIST_SAT : mem_rdata0.hop[DW-1:0];
				end
				state_d = apsp_pkg::ST_DONE;
			end
			apsp_pkg::ST_ROW_RD: begin
				mem_raddr0 = {r_q, m_q};
				state_d    = apsp_pkg::ST_ROW_CHK;
			end
			apsp_pkg::ST_ROW_CHK: begin
				// skip rows that cannot reach the intermediate vertex
				if (mem_rdata0.reach) begin
					drm_d   = mem_rdata0.hop;
					c_d     = '0;
					state_d = apsp_pkg::ST_COL_RD;
				end else begin
					state_d = adv_state;
					m_d     = adv_m;
					r_d     = adv_r;
				end
			end
			apsp_pkg::ST_COL_RD: begin
				mem_raddr0 = {m_q, c_q};
				mem_raddr1 = {r_q, c_q};
				state_d    = apsp_pkg::ST_COL_WR;
			end
			apsp_pkg::ST_COL_WR: begin
				// write back when the intermediate vertex reaches the column and the detour is shorter or the pair was unreachable
				if (mem_rdata0.reach &&
				    (!mem_rdata1.reach || (via < {1'b0, mem_rdata1.hop}))) begin
					mem_we          = 1'b1;
					mem_waddr       = {r_q, c_q};
					mem_wdata.reach = 1'b1;
					mem_wdata.hop   = via[HW-1:0];
				end
				if (c_q == last_q) begin
					state_d = adv_state;
					m_d     = adv_m;
					r_d     = adv_r;
				end else begin
					c_d     = c_q + IDX_W'(1);
					state_d = apsp_pkg::ST_COL_RD;
				end
			end
			apsp_pkg::ST_DONE: begin
				if (res_free) begin
					clr_resp_d = 1'b0;
					state_d    = apsp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = apsp_pkg::ST_IDLE;
			end
		endcase
	end

	// control state; reset starts a clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= apsp_pkg::ST_CLEAR;
			vc_q       <= '0;
			m_q        <= '0;
			r_q        <= '0;
			c_q        <= '0;
			last_q     <= '0;
			clr_resp_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			vc_q       <= vc_d;
			m_q        <= m_d;
			r_q        <= r_d;
			c_q        <= c_d;
			last_q     <= last_d;
			clr_resp_q <= clr_resp_d;
		end
	end

	// operands and result fields
	always_ff @(posedge clk) begin
		ia_q        <= ia_d;
		ib_q        <= ib_d;
		drm_q       <= drm_d;
		res_dist_q  <= res_dist_d;
		res_reach_q <= res_reach_d;
		res_stat_q  <= res_stat_d;
	end

endmodule

// File: src/all_pairs_shortest_path_unweighted_unit.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_unweighted_unit: all-pairs shortest hop counts
// Command-driven distance store with Floyd-Warshall relaxation.
// ----------------------------------------------------------------------------
// Takes one command word at a time and returns one result word per command.
// With N = MAX_NODES: reset and the clear command sweep all N*N entries of
// the store, one entry per cycle, during which no command is taken; a clear
// returns its word when the sweep is done. Add edge writes the entry both
// ways, and writes nothing for a self loop or a bad index. Each relaxation
// step of compute reads two entries and writes at most one back through the
// single write port of the store. The next command is taken as soon as the
// result word is loaded, even while it waits at the output.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_unweighted_unit #(
	parameter int MAX_NODES = apsp_pkg::MAX_NODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  apsp_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output apsp_pkg::out_word_t  out_data
);

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int ADDR_W = 2 * IDX_W;

	logic                res_valid;
	logic                res_free;
	apsp_pkg::out_word_t res_data;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	apsp_pkg::entry_t    mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr0;
	logic [ADDR_W-1:0]   mem_raddr1;
	apsp_pkg::entry_t    mem_rdata0;
	apsp_pkg::entry_t    mem_rdata1;

	logic                out_valid_q;
	apsp_pkg::out_word_t out_data_q;

	apsp_ctrl #(
		.MAX_NODES (MAX_NODES),
		.IDX_W     (IDX_W),
		.ADDR_W    (ADDR_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.res_valid  (res_valid),
		.res_free   (res_free),
		.res_data   (res_data),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr0 (mem_raddr0),
		.mem_raddr1 (mem_raddr1),
		.mem_rdata0 (mem_rdata0),
		.mem_rdata1 (mem_rdata1)
	);

	apsp_mem #(
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr0 (mem_raddr0),
		.raddr1 (mem_raddr1),
		.rdata0 (mem_rdata0),
		.rdata1 (mem_rdata1)
	);

	// hold the result word until taken; load a new one when free
	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef ASSERT_OFF
	// a command leaves the sequencer busy in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while previous still in progress");

	// an error word carries no distance
	a_error_no_distance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> !out_data.reachable && out_data.distance == '0)
		else $error("error word reports a distance");

	// a nonzero distance belongs to a reachable pair
	a_distance_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.distance != '0 |-> out_data.reachable)
		else $error("distance reported for unreachable pair");

	// vertex count stays within the store
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.node_count) <= MAX_NODES)
		else $error("vertex count beyond store size");
`endif

endmodule
